FILE: hw/rtl/assert_macros.svh
// Assertion shorthands, all sampled on clock and quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/adq_pkg.sv
`timescale 1ns / 1ps
package adq_pkg;

   localparam int STAGES   = 7;
   localparam int ST_FRONT = 1;
   localparam int ST_PREP  = 2;
   localparam int ST_MUL   = 3;
   localparam int ST_CLIP  = 4;
   localparam int ST_PROD  = 5;
   localparam int ST_ACC   = 6;
   localparam int ST_OUT   = 7;

   typedef logic [STAGES:1] stage_vec_type;

   localparam int COEF_BITS      = 16;
   localparam int SINE_MAG_BITS  = 15;
   localparam int INV_SQRT3_BITS = 17;
   localparam logic signed [INV_SQRT3_BITS-1:0] INV_SQRT3_Q16 = 17'sd37837;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int WIDE_BITS = 40;

   typedef struct packed {
      logic                         hit;
      logic signed [WIDE_BITS-1:0]  value;
   } clip_type;

   // clamp to the signed range of the given width
   function automatic clip_type clip_sample(input logic signed [WIDE_BITS-1:0] v,
                                            input int unsigned bits);
      logic signed [WIDE_BITS-1:0] hi;
      clip_type r;
      hi = (WIDE_BITS'(1) << (bits - 1)) - WIDE_BITS'(1);
      r.hit   = 1'b0;
      r.value = v;
      if (v > hi) begin
         r.hit   = 1'b1;
         r.value = hi;
      end else if (v < ~hi) begin
         r.hit   = 1'b1;
         r.value = ~hi;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/abc_to_dq0_transform.sv
// Three-phase abc to dq0 transform: amplitude-invariant Clarke, then Park rotation with
// sine and cosine from a quarter-wave table of SINE_TABLE_DEPTH+1 entries read at two
// addresses per word. Takes one word per clock while rsp_ready does not hold the output
// and returns each result through the seven-stage pipeline (sums, magnitudes and beta
// product, divide by three and table read, saturation, Park products, rotation sums,
// rounding and saturation). Every stage has its own valid bit and holds only when the
// stage after it is full, so empty stages keep filling while a finished result waits.
// All outputs saturate to the signed sample range and saturated flags any clipping.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module abc_to_dq0_transform #(
   parameter int SAMPLE_BITS      = 16,
   parameter int ANGLE_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_phase_a,
   input  logic signed [SAMPLE_BITS-1:0] req_phase_b,
   input  logic signed [SAMPLE_BITS-1:0] req_phase_c,
   input  logic [ANGLE_BITS-1:0]         req_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_alpha,
   output logic signed [SAMPLE_BITS-1:0] rsp_beta,
   output logic signed [SAMPLE_BITS-1:0] rsp_zero_seq,
   output logic signed [SAMPLE_BITS-1:0] rsp_d_axis,
   output logic signed [SAMPLE_BITS-1:0] rsp_q_axis,
   output logic                          rsp_saturated
);

   adq_pkg::stage_vec_type valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[adq_pkg::STAGES] = !valid_ff[adq_pkg::STAGES] || rsp_ready;
      for (int k = adq_pkg::STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign valid_in = {valid_ff[adq_pkg::STAGES-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= adq_pkg::STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = stage_en[adq_pkg::ST_FRONT];
   assign rsp_valid = valid_ff[adq_pkg::ST_OUT];

   logic signed [SAMPLE_BITS-1:0]        alpha_c, beta_c, zero_c;
   logic                                 clip_c;
   logic signed [adq_pkg::COEF_BITS-1:0] sine, cosine;

   adq_clarke #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_clarke (
      .clock   (clock),
      .stage_en(stage_en),
      .phase_a (req_phase_a),
      .phase_b (req_phase_b),
      .phase_c (req_phase_c),
      .alpha   (alpha_c),
      .beta    (beta_c),
      .zero_seq(zero_c),
      .clipped (clip_c)
   );

   adq_sincos #(
      .ANGLE_BITS      (ANGLE_BITS),
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_sincos (
      .clock   (clock),
      .stage_en(stage_en),
      .angle   (req_angle),
      .sine    (sine),
      .cosine  (cosine)
   );

   adq_park #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_park (
      .clock    (clock),
      .stage_en (stage_en),
      .alpha    (alpha_c),
      .beta     (beta_c),
      .zero_seq (zero_c),
      .clipped  (clip_c),
      .sine     (sine),
      .cosine   (cosine),
      .alpha_out(rsp_alpha),
      .beta_out (rsp_beta),
      .zero_out (rsp_zero_seq),
      .d_axis   (rsp_d_axis),
      .q_axis   (rsp_q_axis),
      .saturated(rsp_saturated)
   );

   `ASSERT_NEXT(a_accept_enters, req_valid && req_ready, valid_ff[adq_pkg::ST_FRONT], "accepted word not in first stage")
   `ASSERT_SAME(a_ready_only_full, !req_ready, &valid_ff, "input stalled with an empty stage")
   `ASSERT_NEXT(a_held_stage_kept, valid_ff[adq_pkg::ST_ACC] && !stage_en[adq_pkg::ST_OUT], valid_ff[adq_pkg::ST_ACC], "held word dropped")
   `ASSERT_NEXT(a_drain_empties, rsp_valid && rsp_ready && !valid_ff[adq_pkg::ST_ACC], !rsp_valid, "result repeated")

endmodule

FILE: hw/rtl/adq_clarke.sv
`timescale 1ns / 1ps
module adq_clarke #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  adq_pkg::stage_vec_type        stage_en,
   input  logic signed [SAMPLE_BITS-1:0] phase_a,
   input  logic signed [SAMPLE_BITS-1:0] phase_b,
   input  logic signed [SAMPLE_BITS-1:0] phase_c,
   output logic signed [SAMPLE_BITS-1:0] alpha,
   output logic signed [SAMPLE_BITS-1:0] beta,
   output logic signed [SAMPLE_BITS-1:0] zero_seq,
   output logic                          clipped
);

   localparam int SUM_BITS   = SAMPLE_BITS + 2;
   localparam int MAG_BITS   = SAMPLE_BITS + 1;
   localparam int QUO_BITS   = MAG_BITS - 1;
   localparam int DIV3_SHIFT = MAG_BITS + 2;
   localparam int DIV3_PBITS = 2 * MAG_BITS + 1;
   localparam logic [MAG_BITS:0] DIV3_MUL =
      (MAG_BITS + 1)'((64'd1 << DIV3_SHIFT) / 64'd3 + 64'd1);
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + adq_pkg::INV_SQRT3_BITS;
   localparam int BETA_BITS  = PROD_BITS - 16;
   localparam logic signed [PROD_BITS-1:0] BETA_HALF    = PROD_BITS'(32768);
   localparam logic signed [PROD_BITS-1:0] BETA_HALF_M1 = PROD_BITS'(32767);

   // stage 1: sums
   logic signed [SUM_BITS-1:0]  a_x, b_x, c_x;
   logic signed [SUM_BITS-1:0]  sum_a_in, sum_z_in, sum_a_ff, sum_z_ff;
   logic signed [DIFF_BITS-1:0] diff_in, diff_ff;

   assign a_x      = SUM_BITS'(phase_a);
   assign b_x      = SUM_BITS'(phase_b);
   assign c_x      = SUM_BITS'(phase_c);
   assign sum_a_in = (a_x <<< 1) - b_x - c_x;
   assign sum_z_in = a_x + b_x + c_x;
   assign diff_in  = DIFF_BITS'(phase_b) - DIFF_BITS'(phase_c);

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_FRONT]) begin
         sum_a_ff <= sum_a_in;
         sum_z_ff <= sum_z_in;
         diff_ff  <= diff_in;
      end
   end

   // stage 2: magnitudes for the divide by three, beta product
   logic signed [SUM_BITS-1:0]  abs_a, abs_z;
   logic [MAG_BITS-1:0]         mag_a_in, mag_z_in, mag_a_ff, mag_z_ff;
   logic                        neg_a2_ff, neg_z2_ff;
   logic signed [PROD_BITS-1:0] bprod_in, bprod_ff;

   assign abs_a    = sum_a_ff[SUM_BITS-1] ? -sum_a_ff : sum_a_ff;
   assign abs_z    = sum_z_ff[SUM_BITS-1] ? -sum_z_ff : sum_z_ff;
   assign mag_a_in = MAG_BITS'(abs_a) + MAG_BITS'(1);
   assign mag_z_in = MAG_BITS'(abs_z) + MAG_BITS'(1);
   assign bprod_in = diff_ff * adq_pkg::INV_SQRT3_Q16;

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_PREP]) begin
         mag_a_ff  <= mag_a_in;
         mag_z_ff  <= mag_z_in;
         neg_a2_ff <= sum_a_ff[SUM_BITS-1];
         neg_z2_ff <= sum_z_ff[SUM_BITS-1];
         bprod_ff  <= bprod_in;
      end
   end

   // stage 3: divide by three via reciprocal, beta rounding
   logic [DIV3_PBITS-1:0]       qp_a, qp_z;
   logic [QUO_BITS-1:0]         quo_a_in, quo_z_in, quo_a_ff, quo_z_ff;
   logic                        neg_a3_ff, neg_z3_ff;
   logic signed [PROD_BITS-1:0] bbias, bsum;
   logic signed [BETA_BITS-1:0] beta_r_in, beta_r_ff;

   assign qp_a      = DIV3_PBITS'(mag_a_ff) * DIV3_PBITS'(DIV3_MUL);
   assign qp_z      = DIV3_PBITS'(mag_z_ff) * DIV3_PBITS'(DIV3_MUL);
   assign quo_a_in  = QUO_BITS'(qp_a >> DIV3_SHIFT);
   assign quo_z_in  = QUO_BITS'(qp_z >> DIV3_SHIFT);
   assign bbias     = bprod_ff[PROD_BITS-1] ? BETA_HALF_M1 : BETA_HALF;
   assign bsum      = bprod_ff + bbias;
   assign beta_r_in = BETA_BITS'(bsum >>> 16);

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_MUL]) begin
         quo_a_ff  <= quo_a_in;
         quo_z_ff  <= quo_z_in;
         neg_a3_ff <= neg_a2_ff;
         neg_z3_ff <= neg_z2_ff;
         beta_r_ff <= beta_r_in;
      end
   end

   // stage 4: restore sign, saturate
   logic signed [adq_pkg::WIDE_BITS-1:0] qa_w, qz_w;
   adq_pkg::clip_type alpha_c, beta_c, zero_c;
   logic signed [SAMPLE_BITS-1:0] alpha_ff, beta_ff, zero_ff;
   logic                          clip_ff;

   assign qa_w    = adq_pkg::WIDE_BITS'(quo_a_ff);
   assign qz_w    = adq_pkg::WIDE_BITS'(quo_z_ff);
   assign alpha_c = adq_pkg::clip_sample(neg_a3_ff ? -qa_w : qa_w, SAMPLE_BITS);
   assign zero_c  = adq_pkg::clip_sample(neg_z3_ff ? -qz_w : qz_w, SAMPLE_BITS);
   assign beta_c  = adq_pkg::clip_sample(adq_pkg::WIDE_BITS'(beta_r_ff), SAMPLE_BITS);

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_CLIP]) begin
         alpha_ff <= SAMPLE_BITS'(alpha_c.value);
         beta_ff  <= SAMPLE_BITS'(beta_c.value);
         zero_ff  <= SAMPLE_BITS'(zero_c.value);
         clip_ff  <= alpha_c.hit | beta_c.hit | zero_c.hit;
      end
   end

   assign alpha    = alpha_ff;
   assign beta     = beta_ff;
   assign zero_seq = zero_ff;
   assign clipped  = clip_ff;

endmodule

FILE: hw/rtl/adq_sincos.sv
`timescale 1ns / 1ps
module adq_sincos #(
   parameter int ANGLE_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  adq_pkg::stage_vec_type               stage_en,
   input  logic [ANGLE_BITS-1:0]                angle,
   output logic signed [adq_pkg::COEF_BITS-1:0] sine,
   output logic signed [adq_pkg::COEF_BITS-1:0] cosine
);

   localparam int REST_BITS  = ANGLE_BITS - 2;
   localparam int INDEX_BITS = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SCALE_BITS = REST_BITS + INDEX_BITS;
   localparam int CB         = adq_pkg::COEF_BITS;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef logic [adq_pkg::SINE_MAG_BITS-1:0] rom_type [0:SINE_TABLE_DEPTH];

   // quarter wave, Q30 Taylor series rounded to Q15
   function automatic rom_type build_rom();
      rom_type          rom;
      longint unsigned  x;
      longint unsigned  term;
      longint unsigned  acc;
      longint unsigned  e;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (64'(k) * adq_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
         term = x;
         acc  = x;
         for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         e = (acc + 64'd16384) >> 15;
         if (e > 64'd32767) begin
            e = 64'd32767;
         end
         rom[k] = adq_pkg::SINE_MAG_BITS'(e);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // stage 1: scale angle to table index
   logic [SCALE_BITS-1:0] scaled;
   logic [INDEX_BITS-1:0] idx_in, idx_ff;
   logic [1:0]            quad1_ff;

   assign scaled = SCALE_BITS'(angle[REST_BITS-1:0]) * SCALE_BITS'(SINE_TABLE_DEPTH);
   assign idx_in = INDEX_BITS'(scaled >> REST_BITS);

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_FRONT]) begin
         idx_ff   <= idx_in;
         quad1_ff <= angle[ANGLE_BITS-1:REST_BITS];
      end
   end

   // stage 2: both read addresses
   logic [INDEX_BITS-1:0] addr_lo_ff, addr_hi_ff;
   logic [1:0]            quad2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_PREP]) begin
         addr_lo_ff <= idx_ff;
         addr_hi_ff <= INDEX_BITS'(SINE_TABLE_DEPTH) - idx_ff;
         quad2_ff   <= quad1_ff;
      end
   end

   // stage 3: table read, two ports
   logic [adq_pkg::SINE_MAG_BITS-1:0] t_lo_ff, t_hi_ff;
   logic [1:0]                        quad3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_MUL]) begin
         t_lo_ff  <= SINE_ROM[addr_lo_ff];
         t_hi_ff  <= SINE_ROM[addr_hi_ff];
         quad3_ff <= quad2_ff;
      end
   end

   // stage 4: quadrant fold
   logic signed [CB-1:0] pos_lo, pos_hi;
   logic signed [CB-1:0] sine_in, cosine_in, sine_ff, cosine_ff;

   assign pos_lo = $signed(CB'(t_lo_ff));
   assign pos_hi = $signed(CB'(t_hi_ff));

   always_comb begin
      case (quad3_ff)
         QUAD_FIRST: begin
            sine_in   = pos_lo;
            cosine_in = pos_hi;
         end
         QUAD_SECOND: begin
            sine_in   = pos_hi;
            cosine_in = -pos_lo;
         end
         QUAD_THIRD: begin
            sine_in   = -pos_lo;
            cosine_in = -pos_hi;
         end
         QUAD_FOURTH: begin
            sine_in   = -pos_hi;
            cosine_in = pos_lo;
         end
         default: begin
            sine_in   = pos_lo;
            cosine_in = pos_hi;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_CLIP]) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign sine   = sine_ff;
   assign cosine = cosine_ff;

endmodule

FILE: hw/rtl/adq_park.sv
`timescale 1ns / 1ps
module adq_park #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  adq_pkg::stage_vec_type               stage_en,
   input  logic signed [SAMPLE_BITS-1:0]        alpha,
   input  logic signed [SAMPLE_BITS-1:0]        beta,
   input  logic signed [SAMPLE_BITS-1:0]        zero_seq,
   input  logic                                 clipped,
   input  logic signed [adq_pkg::COEF_BITS-1:0] sine,
   input  logic signed [adq_pkg::COEF_BITS-1:0] cosine,
   output logic signed [SAMPLE_BITS-1:0]        alpha_out,
   output logic signed [SAMPLE_BITS-1:0]        beta_out,
   output logic signed [SAMPLE_BITS-1:0]        zero_out,
   output logic signed [SAMPLE_BITS-1:0]        d_axis,
   output logic signed [SAMPLE_BITS-1:0]        q_axis,
   output logic                                 saturated
);

   localparam int PRD_BITS = SAMPLE_BITS + adq_pkg::COEF_BITS;
   localparam int ACC_BITS = PRD_BITS + 1;
   localparam logic signed [ACC_BITS-1:0] HALF    = ACC_BITS'(16384);
   localparam logic signed [ACC_BITS-1:0] HALF_M1 = ACC_BITS'(16383);

   // stage 5: four products
   logic signed [PRD_BITS-1:0]    ca_in, sb_in, cb_in, sa_in;
   logic signed [PRD_BITS-1:0]    ca_ff, sb_ff, cb_ff, sa_ff;
   logic signed [SAMPLE_BITS-1:0] a5_ff, b5_ff, z5_ff;
   logic                          c5_ff;

   assign ca_in = cosine * alpha;
   assign sb_in = sine * beta;
   assign cb_in = cosine * beta;
   assign sa_in = sine * alpha;

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_PROD]) begin
         ca_ff <= ca_in;
         sb_ff <= sb_in;
         cb_ff <= cb_in;
         sa_ff <= sa_in;
         a5_ff <= alpha;
         b5_ff <= beta;
         z5_ff <= zero_seq;
         c5_ff <= clipped;
      end
   end

   // stage 6: rotate
   logic signed [ACC_BITS-1:0]    d_sum_ff, q_sum_ff;
   logic signed [SAMPLE_BITS-1:0] a6_ff, b6_ff, z6_ff;
   logic                          c6_ff;

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_ACC]) begin
         d_sum_ff <= ACC_BITS'(ca_ff) + ACC_BITS'(sb_ff);
         q_sum_ff <= ACC_BITS'(cb_ff) - ACC_BITS'(sa_ff);
         a6_ff    <= a5_ff;
         b6_ff    <= b5_ff;
         z6_ff    <= z5_ff;
         c6_ff    <= c5_ff;
      end
   end

   // stage 7: round half away from zero, saturate
   logic signed [ACC_BITS-1:0] d_bias, q_bias, d_rnd, q_rnd;
   adq_pkg::clip_type          d_c, q_c;

   assign d_bias = d_sum_ff[ACC_BITS-1] ? HALF_M1 : HALF;
   assign q_bias = q_sum_ff[ACC_BITS-1] ? HALF_M1 : HALF;
   assign d_rnd  = (d_sum_ff + d_bias) >>> 15;
   assign q_rnd  = (q_sum_ff + q_bias) >>> 15;
   assign d_c    = adq_pkg::clip_sample(adq_pkg::WIDE_BITS'(d_rnd), SAMPLE_BITS);
   assign q_c    = adq_pkg::clip_sample(adq_pkg::WIDE_BITS'(q_rnd), SAMPLE_BITS);

   logic signed [SAMPLE_BITS-1:0] a7_ff, b7_ff, z7_ff, d_ff, q_ff;
   logic                          sat_ff;

   always_ff @(posedge clock) begin
      if (stage_en[adq_pkg::ST_OUT]) begin
         a7_ff  <= a6_ff;
         b7_ff  <= b6_ff;
         z7_ff  <= z6_ff;
         d_ff   <= SAMPLE_BITS'(d_c.value);
         q_ff   <= SAMPLE_BITS'(q_c.value);
         sat_ff <= c6_ff | d_c.hit | q_c.hit;
      end
   end

   assign alpha_out = a7_ff;
   assign beta_out  = b7_ff;
   assign zero_out  = z7_ff;
   assign d_axis    = d_ff;
   assign q_axis    = q_ff;
   assign saturated = sat_ff;

endmodule
